>>> rtl/core/mcd_pkg.sv
// Shared types and constants of the multi-click detector.
package mcd_pkg;

	typedef enum logic [2:0] {
		REQ_PRESS   = 3'd0,
		REQ_TOUCH   = 3'd1,
		REQ_MOTION  = 3'd2,
		REQ_RELEASE = 3'd3,
		REQ_CANCEL  = 3'd4,
		REQ_TICK    = 3'd5
	} req_t;

	typedef enum logic [1:0] {
		KIND_PRESSED  = 2'd0,
		KIND_RELEASED = 2'd1,
		KIND_STOPPED  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		CFG_TIMEOUT     = 3'd0,
		CFG_DISTANCE    = 3'd1,
		CFG_AREA_EN     = 3'd2,
		CFG_AREA_LEFT   = 3'd3,
		CFG_AREA_TOP    = 3'd4,
		CFG_AREA_WIDTH  = 3'd5,
		CFG_AREA_HEIGHT = 3'd6
	} cfg_idx_t;

	localparam int QUEUE_DEPTH_DEFAULT = 2;

	localparam logic [7:0]  COUNT_MAX        = 8'd255;
	localparam logic [7:0]  TOUCH_BUTTON     = 8'd1;
	localparam logic [15:0] TIMEOUT_RESET    = 16'd400;
	localparam logic [9:0]  DISTANCE_RESET   = 10'd5;
	localparam logic [15:0] AREA_SIZE_RESET  = 16'hFFFF;

	typedef struct packed {
		logic               has_stop;
		logic               has_main;
		kind_t              kind;
		logic [7:0]         num;
		logic signed [15:0] x;
		logic signed [15:0] y;
	} job_t;

endpackage

>>> rtl/core/mcd_front.sv
// Front end: configuration registers, run state and classification of each input event.
module mcd_front import mcd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         req_type,
	input  logic [7:0]         button,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic               q_full,
	output logic               push,
	output job_t               push_job
);

	logic [15:0]        timeout_q;
	logic [9:0]         distance_q;
	logic               area_en_q;
	logic signed [15:0] area_left_q;
	logic signed [15:0] area_top_q;
	logic [15:0]        area_width_q;
	logic [15:0]        area_height_q;

	logic [7:0]         count_q, count_d;
	logic [7:0]         rel_q, rel_d;
	logic [7:0]         active_q, active_d;
	logic signed [15:0] first_x_q, first_x_d;
	logic signed [15:0] first_y_q, first_y_d;
	logic [15:0]        timer_q, timer_d;
	logic               running_q, running_d;

	logic               accept;
	req_t               req;
	logic [7:0]         btn_eff;
	logic signed [16:0] dx, dy;
	logic [16:0]        abs_x, abs_y;
	logic signed [17:0] x_ext, y_ext, left_ext, top_ext, right_ext, bottom_ext;
	logic               close, area_ok, near_pos;
	logic               stop1, stop2;
	logic [7:0]         count_a, count_b, num;
	logic [15:0]        timer_dec;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_full;
	assign accept    = in_valid && !q_full;
	assign req       = req_t'(req_type);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q     <= TIMEOUT_RESET;
			distance_q    <= DISTANCE_RESET;
			area_en_q     <= 1'b0;
			area_left_q   <= '0;
			area_top_q    <= '0;
			area_width_q  <= AREA_SIZE_RESET;
			area_height_q <= AREA_SIZE_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_TIMEOUT:     timeout_q     <= cfg_data;
				CFG_DISTANCE:    distance_q    <= cfg_data[9:0];
				CFG_AREA_EN:     area_en_q     <= cfg_data[0];
				CFG_AREA_LEFT:   area_left_q   <= cfg_data;
				CFG_AREA_TOP:    area_top_q    <= cfg_data;
				CFG_AREA_WIDTH:  area_width_q  <= cfg_data;
				CFG_AREA_HEIGHT: area_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Distance test against the first press of the run and area test against the configured area.
	always_comb begin
		dx         = {pos_x[15], pos_x} - {first_x_q[15], first_x_q};
		dy         = {pos_y[15], pos_y} - {first_y_q[15], first_y_q};
		abs_x      = dx[16] ? 17'(-dx) : 17'(dx);
		abs_y      = dy[16] ? 17'(-dy) : 17'(dy);
		close      = (abs_x < {7'd0, distance_q}) && (abs_y < {7'd0, distance_q});
		x_ext      = {{2{pos_x[15]}}, pos_x};
		y_ext      = {{2{pos_y[15]}}, pos_y};
		left_ext   = {{2{area_left_q[15]}}, area_left_q};
		top_ext    = {{2{area_top_q[15]}}, area_top_q};
		right_ext  = left_ext + $signed({2'b00, area_width_q});
		bottom_ext = top_ext + $signed({2'b00, area_height_q});
		area_ok    = !area_en_q || (x_ext >= left_ext && x_ext < right_ext &&
			y_ext >= top_ext && y_ext < bottom_ext);
		near_pos   = close && area_ok;
	end

	always_comb begin
		btn_eff   = (req == REQ_TOUCH) ? TOUCH_BUTTON : button;
		stop1     = (count_q != 8'd0) && (active_q != btn_eff);
		count_a   = stop1 ? 8'd0 : count_q;
		stop2     = (count_a != 8'd0) && !near_pos;
		count_b   = stop2 ? 8'd0 : count_a;
		num       = (count_b == COUNT_MAX) ? COUNT_MAX : count_b + 8'd1;
		timer_dec = timer_q - {15'd0, timer_q != 16'd0};

		count_d   = count_q;
		rel_d     = rel_q;
		active_d  = active_q;
		first_x_d = first_x_q;
		first_y_d = first_y_q;
		timer_d   = timer_q;
		running_d = running_q;

		push_job          = '0;
		push_job.kind     = KIND_PRESSED;
		push_job.x        = pos_x;
		push_job.y        = pos_y;

		unique case (req) inside
			REQ_PRESS, REQ_TOUCH: begin
				push_job.has_stop = stop1 || stop2;
				push_job.has_main = 1'b1;
				push_job.kind     = KIND_PRESSED;
				push_job.num      = num;
				count_d           = num;
				rel_d             = num;
				active_d          = stop2 ? 8'd0 : btn_eff;
				timer_d           = (timeout_q == 16'd0) ? 16'd1 : timeout_q;
				running_d         = 1'b1;
				if (count_b == 8'd0) begin
					first_x_d = pos_x;
					first_y_d = pos_y;
				end
			end
			REQ_MOTION: begin
				if (count_q != 8'd0 && !near_pos) begin
					push_job.has_stop = 1'b1;
					count_d           = 8'd0;
					active_d          = 8'd0;
				end
			end
			REQ_RELEASE: begin
				push_job.has_main = 1'b1;
				push_job.kind     = KIND_RELEASED;
				push_job.num      = rel_q;
				rel_d             = 8'd0;
			end
			REQ_CANCEL: begin
				if (count_q != 8'd0) begin
					push_job.has_stop = 1'b1;
					count_d           = 8'd0;
					active_d          = 8'd0;
				end
			end
			REQ_TICK: begin
				if (running_q) begin
					timer_d = timer_dec;
					if (timer_dec == 16'd0) begin
						running_d = 1'b0;
						if (count_q != 8'd0) begin
							push_job.has_stop = 1'b1;
							count_d           = 8'd0;
							active_d          = 8'd0;
						end
					end
				end
			end
			default: ;
		endcase

		push = accept && (push_job.has_stop || push_job.has_main);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			rel_q     <= '0;
			active_q  <= '0;
			first_x_q <= '0;
			first_y_q <= '0;
			timer_q   <= '0;
			running_q <= 1'b0;
		end else if (accept) begin
			count_q   <= count_d;
			rel_q     <= rel_d;
			active_q  <= active_d;
			first_x_q <= first_x_d;
			first_y_q <= first_y_d;
			timer_q   <= timer_d;
			running_q <= running_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_timer_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> timer_q != 16'd0)
		else $error("Timer is running with zero ticks left.");
`endif

endmodule

>>> rtl/core/mcd_queue.sv
// Short job queue between the front end and the result sequencer.
module mcd_queue import mcd_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic nonempty,
	output job_t head
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full     = (cnt_q == CW'(DEPTH));
	assign nonempty = (cnt_q != '0);
	assign head     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("Job pushed into a full queue.");
`endif

`ifndef NO_ASSERTIONS
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !nonempty))
		else $error("Job popped from an empty queue.");
`endif

endmodule

>>> rtl/core/mcd_back.sv
// Back end: expands each queued job into its results and holds them in the output register.
module mcd_back import mcd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_nonempty,
	input  job_t               q_head,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         result_kind,
	output logic [7:0]         press_number,
	output logic signed [15:0] out_x,
	output logic signed [15:0] out_y,
	output logic               last
);

	logic               out_valid_q;
	kind_t              kind_q;
	logic [7:0]         num_q;
	logic signed [15:0] x_q, y_q;
	logic               last_q;
	logic               phase_q;
	logic               load;
	logic               emit_stop;

	assign load      = !out_valid_q || !out_stall;
	assign emit_stop = q_head.has_stop && !phase_q;
	assign q_pop     = load && q_nonempty && !(emit_stop && q_head.has_main);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else if (load) begin
			out_valid_q <= q_nonempty;
			if (q_nonempty) begin
				phase_q <= emit_stop && q_head.has_main;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && q_nonempty) begin
			if (emit_stop) begin
				kind_q <= KIND_STOPPED;
				num_q  <= 8'd0;
				x_q    <= '0;
				y_q    <= '0;
				last_q <= !q_head.has_main;
			end else begin
				kind_q <= q_head.kind;
				num_q  <= q_head.num;
				x_q    <= q_head.x;
				y_q    <= q_head.y;
				last_q <= 1'b1;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign result_kind  = kind_q;
	assign press_number = num_q;
	assign out_x        = x_q;
	assign out_y        = y_q;
	assign last         = last_q;

`ifndef NO_ASSERTIONS
	a_phase_job: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (q_nonempty && q_head.has_stop && q_head.has_main))
		else $error("Second result pending without a two-result job at the head.");
`endif

endmodule

>>> rtl/core/multi_click_detector_core.sv
// Top level of the multi-click detector core.
// Usage:
//   Input events arrive on in_valid/in_stall with req_type, button, pos_x and pos_y;
//   a transaction completes when in_valid is high and in_stall is low.
//   Results leave on out_valid/out_stall; last marks the final result of an event.
//   Registers must be written via cfg_valid/cfg_ready/cfg_index/cfg_data by the
//   user only while idle; the block does not enforce it; cfg_ready is always high.
// Flow and throughput:
//   The front end classifies an event and updates the run state in the cycle it is
//   accepted, so a new event can be taken every cycle while the job queue has room.
//   The first result reaches the output register through the job queue.
//   The back end delivers one result per cycle while out_stall is low, so an event
//   with a stop and a press result emits both; events without results use no slot.
// Stalls:
//   While out_stall is high the output register holds; the queue of QUEUE_DEPTH jobs
//   fills and then in_stall rises until the receiver takes results again.
// Reset:
//   arst_n restores the register defaults, clears the run state and empties the queue.
module multi_click_detector_core import mcd_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         req_type,
	input  logic [7:0]         button,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         result_kind,
	output logic [7:0]         press_number,
	output logic signed [15:0] out_x,
	output logic signed [15:0] out_y,
	output logic               last
);

	logic push, q_full, q_pop, q_nonempty;
	job_t push_job, q_head;

	mcd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.button    (button),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.q_full    (q_full),
		.push      (push),
		.push_job  (push_job)
	);

	mcd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (q_pop),
		.nonempty (q_nonempty),
		.head     (q_head)
	);

	mcd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_nonempty   (q_nonempty),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_kind  (result_kind),
		.press_number (press_number),
		.out_x        (out_x),
		.out_y        (out_y),
		.last         (last)
	);

endmodule

>>> tb/sv/mcd_checker.sv
// Checker of the multi-click detector: predicts every result and compares it on the output.
`timescale 1ns / 100ps
module mcd_checker import mcd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [2:0]         req_type,
	input  logic [7:0]         button,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [1:0]         result_kind,
	input  logic [7:0]         press_number,
	input  logic signed [15:0] out_x,
	input  logic signed [15:0] out_y,
	input  logic               last,
	output int                 errors,
	output int                 pending
);

	typedef struct {
		kind_t              kind;
		logic [7:0]         num;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic               fin;
	} click_result_t;

	click_result_t due_results[$];

	logic [15:0]        cfg_timeout;
	logic [9:0]         cfg_distance;
	logic               cfg_area_on;
	logic signed [15:0] cfg_left;
	logic signed [15:0] cfg_top;
	logic [15:0]        cfg_width;
	logic [15:0]        cfg_height;

	logic [7:0]         run_count;
	logic [7:0]         held_release;
	logic [7:0]         run_button;
	logic signed [15:0] anchor_x;
	logic signed [15:0] anchor_y;
	logic [15:0]        ticks_left;
	logic               ticking;

	task automatic push_result(kind_t kind, logic [7:0] num, logic signed [15:0] x,
			logic signed [15:0] y);
		due_results.push_back('{kind, num, x, y, 1'b0});
	endtask

	task automatic end_run();
		if (run_count != 8'd0) begin
			run_button = 8'd0;
			run_count = 8'd0;
			push_result(KIND_STOPPED, 8'd0, 16'sd0, 16'sd0);
		end
	endtask

	function automatic bit within_reach(logic signed [15:0] x, logic signed [15:0] y);
		int dx;
		int dy;
		if (run_count == 8'd0)
			return 1'b1;
		dx = int'(anchor_x) - int'(x);
		dy = int'(anchor_y) - int'(y);
		if (dx < 0)
			dx = -dx;
		if (dy < 0)
			dy = -dy;
		if (dx >= int'(cfg_distance) || dy >= int'(cfg_distance))
			return 1'b0;
		if (!cfg_area_on)
			return 1'b1;
		return int'(x) >= int'(cfg_left) && int'(x) < int'(cfg_left) + int'(cfg_width) &&
			int'(y) >= int'(cfg_top) && int'(y) < int'(cfg_top) + int'(cfg_height);
	endfunction

	task automatic predict_clicks(logic [2:0] req, logic [7:0] btn, logic signed [15:0] x,
			logic signed [15:0] y);
		int         size_was;
		logic [7:0] b;
		logic [7:0] num;
		size_was = due_results.size();
		case (req) inside
			REQ_PRESS, REQ_TOUCH: begin
				b = (req == REQ_TOUCH) ? TOUCH_BUTTON : btn;
				if (run_count != 8'd0 && run_button != b)
					end_run();
				run_button = b;
				ticks_left = (cfg_timeout == 16'd0) ? 16'd1 : cfg_timeout;
				ticking = 1'b1;
				if (!within_reach(x, y))
					end_run();
				num = (run_count < COUNT_MAX) ? run_count + 8'd1 : COUNT_MAX;
				held_release = num;
				push_result(KIND_PRESSED, num, x, y);
				if (run_count == 8'd0) begin
					anchor_x = x;
					anchor_y = y;
				end
				run_count = num;
			end
			REQ_MOTION: begin
				if (!within_reach(x, y))
					end_run();
			end
			REQ_RELEASE: begin
				push_result(KIND_RELEASED, held_release, x, y);
				held_release = 8'd0;
			end
			REQ_CANCEL: end_run();
			REQ_TICK: begin
				if (ticking) begin
					if (ticks_left != 16'd0)
						ticks_left = ticks_left - 16'd1;
					if (ticks_left == 16'd0) begin
						ticking = 1'b0;
						end_run();
					end
				end
			end
			default: ;
		endcase
		if (due_results.size() > size_was)
			due_results[due_results.size() - 1].fin = 1'b1;
	endtask

	task automatic report_mismatch(bit has_want, click_result_t want);
		errors++;
		if (errors <= 10) begin
			if (has_want)
				$display("%0t: mismatch: expected kind=%0d num=%0d x=%0d y=%0d last=%0b",
					$time, want.kind, want.num, want.x, want.y, want.fin);
			else
				$display("%0t: mismatch: no result was outstanding", $time);
			$display("%0t:           actual   kind=%0d num=%0d x=%0d y=%0d last=%0b",
				$time, result_kind, press_number, out_x, out_y, last);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		click_result_t want;
		if (!arst_n) begin
			cfg_timeout = TIMEOUT_RESET;
			cfg_distance = DISTANCE_RESET;
			cfg_area_on = 1'b0;
			cfg_left = 16'sd0;
			cfg_top = 16'sd0;
			cfg_width = AREA_SIZE_RESET;
			cfg_height = AREA_SIZE_RESET;
			run_count = 8'd0;
			held_release = 8'd0;
			run_button = 8'd0;
			anchor_x = 16'sd0;
			anchor_y = 16'sd0;
			ticks_left = 16'd0;
			ticking = 1'b0;
			due_results.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					want = '{KIND_STOPPED, 8'd0, 16'sd0, 16'sd0, 1'b0};
					report_mismatch(1'b0, want);
				end else begin
					want = due_results.pop_front();
					if (result_kind !== want.kind || press_number !== want.num ||
							out_x !== want.x || out_y !== want.y || last !== want.fin)
						report_mismatch(1'b1, want);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_TIMEOUT:     cfg_timeout = cfg_data;
					CFG_DISTANCE:    cfg_distance = cfg_data[9:0];
					CFG_AREA_EN:     cfg_area_on = cfg_data[0];
					CFG_AREA_LEFT:   cfg_left = cfg_data;
					CFG_AREA_TOP:    cfg_top = cfg_data;
					CFG_AREA_WIDTH:  cfg_width = cfg_data;
					CFG_AREA_HEIGHT: cfg_height = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				predict_clicks(req_type, button, pos_x, pos_y);
			pending = due_results.size();
		end
	end

endmodule

>>> tb/sv/tb.sv
// Testbench top of the multi-click detector: reset, stimulus, stalls and the verdict.
`timescale 1ns / 100ps
module tb import mcd_pkg::*; ();

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 8;
	localparam logic [2:0] REQ_SPARE_LO = 3'd6;
	localparam logic [2:0] REQ_SPARE_HI = 3'd7;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         cfg_index;
	logic [15:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic [2:0]         req_type;
	logic [7:0]         button;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic               out_valid;
	logic               out_stall;
	logic [1:0]         result_kind;
	logic [7:0]         press_number;
	logic signed [15:0] out_x;
	logic signed [15:0] out_y;
	logic               last;

	int errors;
	int pending;
	int cycles = 0;
	int sent_items = 0;
	int burst_left = 0;
	int hold_req = 0;

	int sh_timeout = 400;
	int sh_dist = 5;
	bit sh_area = 1'b0;
	int sh_left = 0;
	int sh_top = 0;
	int sh_w = 65535;
	int sh_h = 65535;

	multi_click_detector_core dut (.*);

	mcd_checker checker_i (.*);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin : receiver
		stall_mode_t mode;
		int          span;
		int          hold_seen;
		int          beat;
		hold_seen = 0;
		beat = 0;
		out_stall = 1'b0;
		forever begin
			mode = stall_mode_t'($urandom_range(0, 3));
			span = $urandom_range(16, 160);
			repeat (span) begin
				@(negedge clk);
				beat++;
				if (hold_req != hold_seen) begin
					hold_seen = hold_req;
					out_stall <= 1'b1;
					repeat (HOLD_CYCLES) @(negedge clk);
				end
				case (mode)
					STALL_NONE:  out_stall <= 1'b0;
					STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
					STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
					default:     out_stall <= (beat % 7) < 3;
				endcase
			end
		end
	end

	function automatic logic signed [15:0] clip(int v);
		if (v > 32767)
			return 16'sh7FFF;
		if (v < -32768)
			return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic int any_pos();
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	function automatic int jitter(int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic int edge_pick(int lo, int w);
		int r;
		case ($urandom_range(0, 2))
			0: r = lo - 2 + int'($urandom_range(0, 4));
			1: r = lo + w - 2 + int'($urandom_range(0, 4));
			default: r = lo + int'($urandom_range(0, w));
		endcase
		return r;
	endfunction

	task automatic pause(int n);
		repeat (n) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
	endtask

	task automatic send_event(logic [2:0] req, logic [7:0] btn, int x, int y);
		if (burst_left == 0) begin
			pause(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8));
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		req_type <= req;
		button <= btn;
		pos_x <= clip(x);
		pos_y <= clip(y);
		do @(posedge clk); while (in_stall);
		if (req <= REQ_TICK)
			sent_items++;
	endtask

	task automatic settle();
		pause(1);
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [15:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_settings(int tmo, int dist_px, bit area, int left, int area_top,
			int w, int h);
		settle();
		write_reg(CFG_TIMEOUT, tmo[15:0]);
		write_reg(CFG_DISTANCE, dist_px[15:0]);
		write_reg(CFG_AREA_EN, {15'd0, area});
		write_reg(CFG_AREA_LEFT, left[15:0]);
		write_reg(CFG_AREA_TOP, area_top[15:0]);
		write_reg(CFG_AREA_WIDTH, w[15:0]);
		write_reg(CFG_AREA_HEIGHT, h[15:0]);
		sh_timeout = (tmo == 0) ? 1 : tmo;
		sh_dist = dist_px;
		sh_area = area;
		sh_left = left;
		sh_top = area_top;
		sh_w = w;
		sh_h = h;
	endtask

	task automatic tick_run(int n);
		repeat (n)
			send_event(REQ_TICK, 8'($urandom), any_pos(), any_pos());
	endtask

	task automatic click_burst();
		int         ax;
		int         ay;
		int         n;
		int         span;
		logic [7:0] b;
		logic [2:0] kind;
		span = (sh_dist > 40) ? 40 : sh_dist + 2;
		if (sh_area && $urandom_range(0, 1) == 1) begin
			ax = edge_pick(sh_left, sh_w);
			ay = edge_pick(sh_top, sh_h);
		end else begin
			ax = any_pos();
			ay = any_pos();
		end
		b = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
		n = $urandom_range(1, 6);
		repeat (n) begin
			kind = ($urandom_range(0, 3) == 0) ? REQ_TOUCH : REQ_PRESS;
			send_event(kind, b, ax + jitter(span), ay + jitter(span));
			if ($urandom_range(0, 9) < 3)
				send_event(REQ_MOTION, 8'($urandom), ax + jitter(span), ay + jitter(span));
			if ($urandom_range(0, 9) < 8)
				send_event(REQ_RELEASE, 8'($urandom), ax + jitter(span), ay + jitter(span));
			if ($urandom_range(0, 9) < 2)
				tick_run($urandom_range(1, 3));
		end
		case ($urandom_range(0, 3))
			0: send_event(REQ_CANCEL, 8'($urandom), any_pos(), any_pos());
			1: if (sh_timeout <= 16) tick_run(sh_timeout);
			default: ;
		endcase
	endtask

	task automatic button_switch();
		int         x;
		int         y;
		logic [7:0] b;
		x = any_pos();
		y = any_pos();
		b = 8'($urandom);
		send_event(REQ_PRESS, b, x, y);
		send_event(REQ_PRESS, b + 8'($urandom_range(1, 255)), x, y);
		send_event(REQ_RELEASE, b, x, y);
	endtask

	task automatic run_phase(int budget);
		int goal;
		int pick;
		goal = sent_items + budget;
		while (sent_items < goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 60)
				click_burst();
			else if (pick < 75)
				send_event(3'($urandom_range(0, 7)), 8'($urandom), any_pos(), any_pos());
			else if (pick < 85)
				button_switch();
			else if (pick < 96)
				tick_run($urandom_range(1, (sh_timeout > 12) ? 4 : sh_timeout + 2));
			else
				settle();
		end
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_TIMEOUT;
		cfg_data = 16'd0;
		in_valid = 1'b0;
		req_type = REQ_TICK;
		button = 8'd0;
		pos_x = 16'sd0;
		pos_y = 16'sd0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		send_event(REQ_RELEASE, 8'd0, 32767, -32768);
		send_event(REQ_TICK, 8'd0, 0, 0);
		send_event(REQ_CANCEL, 8'd255, 0, 0);
		send_event(REQ_MOTION, 8'd0, 32767, 32767);
		send_event(REQ_SPARE_LO, 8'hA5, -1, 12345);
		send_event(REQ_SPARE_HI, 8'h5A, 32767, -32768);
		send_event(REQ_PRESS, 8'd0, -32768, -32768);
		send_event(REQ_RELEASE, 8'd0, -32768, -32768);
		send_event(REQ_PRESS, 8'd0, -32764, -32768);
		send_event(REQ_PRESS, 8'd0, -32763, -32768);
		send_event(REQ_MOTION, 8'd0, -32759, -32767);
		send_event(REQ_MOTION, 8'd0, -32758, -32768);
		send_event(REQ_PRESS, 8'd255, 32767, 32767);
		send_event(REQ_TOUCH, 8'd200, 32767, 32767);
		send_event(REQ_TOUCH, 8'd0, 32766, 32763);
		send_event(REQ_PRESS, 8'd1, 32767, 32767);
		send_event(REQ_RELEASE, 8'd9, 32767, 32767);
		send_event(REQ_RELEASE, 8'd9, 32767, 32767);
		send_event(REQ_CANCEL, 8'd0, 5, 5);
		send_event(REQ_PRESS, 8'd128, 0, 0);
		send_event(REQ_CANCEL, 8'd0, 0, 0);
		send_event(REQ_TICK, 8'd0, 0, 0);
		run_phase(200);

		apply_settings(3, 20, 1'b0, 0, 0, 65535, 65535);
		click_burst();
		hold_req++;
		run_phase(190);

		apply_settings(1, 0, 1'b0, 0, 0, 65535, 65535);
		run_phase(150);

		apply_settings(0, 1023, 1'b1, -32768, -32768, 65535, 65535);
		run_phase(180);

		apply_settings(65535, 1023, 1'b1, 32767, 32767, 0, 0);
		run_phase(150);

		apply_settings(65535, 1023, 1'b1, -100, -50, 200, 120);
		for (int i = 0; i < 268; i++) begin
			send_event(REQ_PRESS, 8'd7, 10 + jitter(3), 10 + jitter(3));
			if (i % 16 == 15)
				send_event(REQ_RELEASE, 8'd7, 10, 10);
		end
		send_event(REQ_MOTION, 8'd7, -32768, 10);
		run_phase(120);

		apply_settings(8, 12, 1'b1, any_pos(), any_pos(), $urandom_range(0, 300),
			$urandom_range(0, 300));
		run_phase(220);

		apply_settings(2, 1, 1'b0, 5, 5, 10, 10);
		run_phase(150);

		settle();
		if (errors == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

>>> multi_click_detector_core.f
rtl/core/mcd_pkg.sv
rtl/core/mcd_front.sv
rtl/core/mcd_queue.sv
rtl/core/mcd_back.sv
rtl/core/multi_click_detector_core.sv
tb/sv/mcd_checker.sv
tb/sv/tb.sv
